// ===== rtl/scbp_pkg.sv =====
// Shared types and constants of the size-class buffer pool.
// No dependencies; every other file of the block but scbp_ram uses this package.

package scbp_pkg;

	localparam int ID_W      = 5;
	localparam int LEN_W     = 7;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 3;
	localparam int CLASS_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0] CUTOFF_SMALL_RST  = 7'd12;
	localparam logic [LEN_W-1:0] CUTOFF_MEDIUM_RST = 7'd86;
	localparam logic [LEN_W-1:0] CUTOFF_LARGE_RST  = 7'd117;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC_PKT  = 3'd0,
		OP_ALLOC_PLD  = 3'd1,
		OP_ALLOC_BOTH = 3'd2,
		OP_FREE_PKT   = 3'd3,
		OP_FREE_PLD   = 3'd4,
		OP_FREE_BOTH  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 3'd0,
		STATUS_NO_PACKET    = 3'd1,
		STATUS_NO_PAYLOAD   = 3'd2,
		STATUS_TOO_LONG     = 3'd3,
		STATUS_PAYLOAD_FULL = 3'd4,
		STATUS_PACKET_FULL  = 3'd5
	} status_code_t;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_SMALL  = 2'd0,
		CLASS_MEDIUM = 2'd1,
		CLASS_LARGE  = 2'd2,
		CLASS_NONE   = 2'd3
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF_SMALL  = 2'd0,
		CFG_CUTOFF_MEDIUM = 2'd1,
		CFG_CUTOFF_LARGE  = 2'd2
	} cfg_index_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;
		logic exec;
	} ctrl_cmd_t;

	// Datapath to one stack.
	typedef struct packed {
		logic push;
		logic pop;
	} lifo_cmd_t;

	// Stack back to datapath.
	typedef struct packed {
		logic empty;
		logic full;
	} lifo_stat_t;

endpackage

// ===== rtl/scbp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module scbp_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/scbp_lifo.sv =====
// One free stack of buffer ids: fill count, low-water mark and a RAM.
// Depends on scbp_pkg and scbp_ram.

module scbp_lifo #(
	parameter int DEPTH = 30,
	parameter int BASE  = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scbp_pkg::lifo_cmd_t         cmd,
	input  logic [scbp_pkg::ID_W-1:0]   push_id,
	output logic [scbp_pkg::ID_W-1:0]   top_id,
	output scbp_pkg::lifo_stat_t        stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [scbp_pkg::ID_W-1:0] TOP_RST_ID = scbp_pkg::ID_W'(BASE + DEPTH - 1);

	logic [CW-1:0] count_q;
	// Slots below the mark were never overwritten and still hold their reset id.
	logic [CW-1:0] low_q;
	logic [CW-1:0] top_idx;
	logic [AW-1:0] raddr;
	logic [scbp_pkg::ID_W-1:0] ram_rdata;
	logic [scbp_pkg::ID_W-1:0] rst_id_q;
	logic                      use_rst_q;

	assign top_idx = count_q - 1'b1;
	assign raddr   = AW'(top_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(DEPTH);
			low_q   <= CW'(DEPTH);
		end else if (cmd.pop) begin
			count_q <= top_idx;
			if (top_idx < low_q) begin
				low_q <= top_idx;
			end
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Track the RAM read latency for the reset-id bypass.
	always_ff @(posedge clk) begin
		use_rst_q <= (top_idx < low_q);
		rst_id_q  <= TOP_RST_ID - scbp_pkg::ID_W'(raddr);
	end

	scbp_ram #(
		.WIDTH (scbp_pkg::ID_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (AW'(count_q)),
		.wdata (push_id),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	assign top_id     = use_rst_q ? rst_id_q : ram_rdata;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

endmodule

// ===== rtl/scbp_datapath.sv =====
// Datapath: cutoff registers, class select, the four free stacks, result registers.
// Depends on scbp_pkg and scbp_lifo.

module scbp_datapath #(
	parameter int PACKET_COUNT = 30,
	parameter int SMALL_COUNT  = 20,
	parameter int MEDIUM_COUNT = 8,
	parameter int LARGE_COUNT  = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  scbp_pkg::ctrl_cmd_t               cmd,
	input  logic [scbp_pkg::OP_W-1:0]         operation,
	input  logic [scbp_pkg::LEN_W-1:0]        payload_length,
	input  logic [scbp_pkg::ID_W-1:0]         packet_id,
	input  logic [scbp_pkg::ID_W-1:0]         payload_id,
	input  logic                              wr_en,
	input  logic [scbp_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [scbp_pkg::LEN_W-1:0]        wr_data,
	output logic [scbp_pkg::STATUS_W-1:0]     status,
	output logic [scbp_pkg::ID_W-1:0]         granted_packet,
	output logic [scbp_pkg::ID_W-1:0]         granted_payload,
	output logic [scbp_pkg::CLASS_W-1:0]      payload_class
);

	logic [scbp_pkg::LEN_W-1:0] cut_small_q, cut_medium_q, cut_large_q;
	logic [scbp_pkg::OP_W-1:0]  op_q;
	logic [scbp_pkg::LEN_W-1:0] len_q;
	logic [scbp_pkg::ID_W-1:0]  pkt_in_q, pld_in_q;

	scbp_pkg::class_t       cls;
	scbp_pkg::lifo_cmd_t    pkt_cmd;
	scbp_pkg::lifo_stat_t   pkt_stat;
	logic [scbp_pkg::ID_W-1:0] pkt_top;
	scbp_pkg::lifo_cmd_t    cls_cmd [3];
	scbp_pkg::lifo_stat_t   cls_stat [3];
	logic [scbp_pkg::ID_W-1:0] cls_top [3];
	scbp_pkg::lifo_stat_t   sel_stat;
	logic [scbp_pkg::ID_W-1:0] sel_top;

	logic pkt_pop, pkt_push, pld_pop, pld_push;
	scbp_pkg::status_code_t    st_d;
	logic [scbp_pkg::ID_W-1:0] gp_d, gl_d;
	logic [scbp_pkg::CLASS_W-1:0] cls_out_d;

	logic [scbp_pkg::STATUS_W-1:0] status_q;
	logic [scbp_pkg::ID_W-1:0]     gp_q, gl_q;
	logic [scbp_pkg::CLASS_W-1:0]  cls_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_small_q  <= scbp_pkg::CUTOFF_SMALL_RST;
			cut_medium_q <= scbp_pkg::CUTOFF_MEDIUM_RST;
			cut_large_q  <= scbp_pkg::CUTOFF_LARGE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				scbp_pkg::CFG_CUTOFF_SMALL:  cut_small_q  <= wr_data;
				scbp_pkg::CFG_CUTOFF_MEDIUM: cut_medium_q <= wr_data;
				scbp_pkg::CFG_CUTOFF_LARGE:  cut_large_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= operation;
			len_q    <= payload_length;
			pkt_in_q <= packet_id;
			pld_in_q <= payload_id;
		end
	end

	// First class in fixed order whose cutoff covers the length.
	always_comb begin
		if (len_q <= cut_small_q) begin
			cls = scbp_pkg::CLASS_SMALL;
		end else if (len_q <= cut_medium_q) begin
			cls = scbp_pkg::CLASS_MEDIUM;
		end else if (len_q <= cut_large_q) begin
			cls = scbp_pkg::CLASS_LARGE;
		end else begin
			cls = scbp_pkg::CLASS_NONE;
		end
	end

	always_comb begin
		sel_top  = '0;
		sel_stat = '{empty: 1'b1, full: 1'b1};
		case (cls)
			scbp_pkg::CLASS_SMALL: begin
				sel_top  = cls_top[0];
				sel_stat = cls_stat[0];
			end
			scbp_pkg::CLASS_MEDIUM: begin
				sel_top  = cls_top[1];
				sel_stat = cls_stat[1];
			end
			scbp_pkg::CLASS_LARGE: begin
				sel_top  = cls_top[2];
				sel_stat = cls_stat[2];
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d      = scbp_pkg::STATUS_OK;
		gp_d      = '0;
		gl_d      = '0;
		cls_out_d = '0;
		pkt_pop   = 1'b0;
		pkt_push  = 1'b0;
		pld_pop   = 1'b0;
		pld_push  = 1'b0;
		if (op_q inside {scbp_pkg::OP_ALLOC_PLD, scbp_pkg::OP_ALLOC_BOTH,
				scbp_pkg::OP_FREE_PLD, scbp_pkg::OP_FREE_BOTH}
				&& cls != scbp_pkg::CLASS_NONE) begin
			cls_out_d = cls;
		end
		unique case (op_q)
			scbp_pkg::OP_ALLOC_PKT: begin
				if (pkt_stat.empty) begin
					st_d = scbp_pkg::STATUS_NO_PACKET;
				end else begin
					gp_d    = pkt_top;
					pkt_pop = 1'b1;
				end
			end
			scbp_pkg::OP_ALLOC_PLD: begin
				if (cls == scbp_pkg::CLASS_NONE) begin
					st_d = scbp_pkg::STATUS_TOO_LONG;
				end else if (sel_stat.empty) begin
					st_d = scbp_pkg::STATUS_NO_PAYLOAD;
				end else begin
					gl_d    = sel_top;
					pld_pop = 1'b1;
				end
			end
			scbp_pkg::OP_ALLOC_BOTH: begin
				// The packet is only taken when the payload succeeds too.
				if (pkt_stat.empty) begin
					st_d = scbp_pkg::STATUS_NO_PACKET;
				end else if (cls == scbp_pkg::CLASS_NONE) begin
					st_d = scbp_pkg::STATUS_TOO_LONG;
				end else if (sel_stat.empty) begin
					st_d = scbp_pkg::STATUS_NO_PAYLOAD;
				end else begin
					gp_d    = pkt_top;
					gl_d    = sel_top;
					pkt_pop = 1'b1;
					pld_pop = 1'b1;
				end
			end
			scbp_pkg::OP_FREE_PKT: begin
				if (pkt_stat.full) begin
					st_d = scbp_pkg::STATUS_PACKET_FULL;
				end else begin
					pkt_push = 1'b1;
				end
			end
			scbp_pkg::OP_FREE_PLD, scbp_pkg::OP_FREE_BOTH: begin
				if (cls == scbp_pkg::CLASS_NONE) begin
					st_d = scbp_pkg::STATUS_TOO_LONG;
				end else if (sel_stat.full) begin
					st_d = scbp_pkg::STATUS_PAYLOAD_FULL;
				end else begin
					pld_push = 1'b1;
					if (op_q == scbp_pkg::OP_FREE_BOTH) begin
						if (pkt_stat.full) begin
							st_d = scbp_pkg::STATUS_PACKET_FULL;
						end else begin
							pkt_push = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign pkt_cmd.pop  = cmd.exec && pkt_pop;
	assign pkt_cmd.push = cmd.exec && pkt_push;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cls_cmd[i].pop  = cmd.exec && pld_pop  && (cls == scbp_pkg::CLASS_W'(i));
			cls_cmd[i].push = cmd.exec && pld_push && (cls == scbp_pkg::CLASS_W'(i));
		end
	end

	scbp_lifo #(.DEPTH(PACKET_COUNT), .BASE(0)) u_pkt (
		.clk(clk), .arst_n(arst_n), .cmd(pkt_cmd), .push_id(pkt_in_q),
		.top_id(pkt_top), .stat(pkt_stat)
	);

	scbp_lifo #(.DEPTH(SMALL_COUNT), .BASE(0)) u_small (
		.clk(clk), .arst_n(arst_n), .cmd(cls_cmd[0]), .push_id(pld_in_q),
		.top_id(cls_top[0]), .stat(cls_stat[0])
	);

	scbp_lifo #(.DEPTH(MEDIUM_COUNT), .BASE(SMALL_COUNT)) u_medium (
		.clk(clk), .arst_n(arst_n), .cmd(cls_cmd[1]), .push_id(pld_in_q),
		.top_id(cls_top[1]), .stat(cls_stat[1])
	);

	scbp_lifo #(.DEPTH(LARGE_COUNT), .BASE(SMALL_COUNT + MEDIUM_COUNT)) u_large (
		.clk(clk), .arst_n(arst_n), .cmd(cls_cmd[2]), .push_id(pld_in_q),
		.top_id(cls_top[2]), .stat(cls_stat[2])
	);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= st_d;
			gp_q      <= gp_d;
			gl_q      <= gl_d;
			cls_out_q <= cls_out_d;
		end
	end

	assign status          = status_q;
	assign granted_packet  = gp_q;
	assign granted_payload = gl_q;
	assign payload_class   = cls_out_q;

endmodule

// ===== rtl/scbp_ctrl.sv =====
// Controller: two-state sequencer that captures a request and executes it.
// Depends on scbp_pkg.

module scbp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output scbp_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	assign busy      = (state_q == ST_EXEC);
	assign done      = done_q;
	assign cmd.latch = start && !busy;
	assign cmd.exec  = (state_q == ST_EXEC);

endmodule

// ===== rtl/size_class_buffer_pool.sv =====
// Top level of the size-class buffer pool.
// Depends on scbp_pkg, scbp_ctrl and scbp_datapath.

// Buffer manager with one free stack of packet descriptors and three free stacks of
// payload buffers (small, medium, large). Issue a request by raising start while busy
// is low; the request is captured at that edge. Each request is captured while the top of
// every stack is read from its RAM, then executed while busy is high, with the pop or
// push. The registered RAM read of the stack tops keeps these steps apart, and no new
// request is taken while busy is high. The result transaction appears on status,
// granted_packet, granted_payload and payload_class for exactly one cycle with done
// high, the cycle after execution; the receiver cannot stall it, so capture it then.
// Write cutoffs through wr_en, wr_index and wr_data only while no request is in
// flight. After reset every stack is full and no clearing pass is needed.
module size_class_buffer_pool #(
	parameter int PACKET_COUNT = 30,
	parameter int SMALL_COUNT  = 20,
	parameter int MEDIUM_COUNT = 8,
	parameter int LARGE_COUNT  = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request transaction
	input  logic                              start,
	output logic                              busy,
	input  logic [scbp_pkg::OP_W-1:0]         operation,
	input  logic [scbp_pkg::LEN_W-1:0]        payload_length,
	input  logic [scbp_pkg::ID_W-1:0]         packet_id,
	input  logic [scbp_pkg::ID_W-1:0]         payload_id,
	// result transaction
	output logic                              done,
	output logic [scbp_pkg::STATUS_W-1:0]     status,
	output logic [scbp_pkg::ID_W-1:0]         granted_packet,
	output logic [scbp_pkg::ID_W-1:0]         granted_payload,
	output logic [scbp_pkg::CLASS_W-1:0]      payload_class,
	// cutoff register writes
	input  logic                              wr_en,
	input  logic [scbp_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [scbp_pkg::LEN_W-1:0]        wr_data
);

	scbp_pkg::ctrl_cmd_t cmd;

	// Sequence capture and execution.
	scbp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold cutoffs, pick the class, pop or push the stacks, register the result.
	scbp_datapath #(
		.PACKET_COUNT (PACKET_COUNT),
		.SMALL_COUNT  (SMALL_COUNT),
		.MEDIUM_COUNT (MEDIUM_COUNT),
		.LARGE_COUNT  (LARGE_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (operation),
		.payload_length  (payload_length),
		.packet_id       (packet_id),
		.payload_id      (payload_id),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.status          (status),
		.granted_packet  (granted_packet),
		.granted_payload (granted_payload),
		.payload_class   (payload_class)
	);

endmodule

// ===== rtl/scbp_checker.sv =====
// Port-level checks of the size-class buffer pool, bound to the top level.
// Depends on scbp_pkg and size_class_buffer_pool.

module scbp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [scbp_pkg::STATUS_W-1:0]     status,
	input logic [scbp_pkg::ID_W-1:0]         granted_packet,
	input logic [scbp_pkg::ID_W-1:0]         granted_payload,
	input logic [scbp_pkg::CLASS_W-1:0]      payload_class
);

	// An accepted request executes in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not execute");

	// Every execution yields exactly one result in the following cycle.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy) else $error("execution without a result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without an execution");

	// A failed request grants nothing.
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != scbp_pkg::STATUS_OK |->
		granted_packet == '0 && granted_payload == '0)
		else $error("grant on a failed request");

	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> payload_class != scbp_pkg::CLASS_NONE)
		else $error("class code out of range");

endmodule

bind size_class_buffer_pool scbp_checker u_scbp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.granted_packet  (granted_packet),
	.granted_payload (granted_payload),
	.payload_class   (payload_class)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for size_class_buffer_pool: a scoreboard class mirrors the four
// free stacks and the cutoffs and checks every result transaction in order.
// Depends on scbp_pkg and the size_class_buffer_pool RTL.
`timescale 1ns / 1ps

module tb_top;
	import scbp_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 100000;

	localparam int PACKET_COUNT = 30;
	localparam int SMALL_COUNT  = 20;
	localparam int MEDIUM_COUNT = 8;
	localparam int LARGE_COUNT  = 2;

	// Operation codes the block ignores: they still return an all-zero result.
	localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

	localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;
	localparam logic [ID_W-1:0]  ID_MAX  = 5'd31;

	typedef struct {
		status_code_t     status;
		logic [ID_W-1:0]  pkt;
		logic [ID_W-1:0]  pld;
		class_t           cls;
	} pool_result_t;

	typedef struct {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} held_payload_t;

	// Mirror of the pool: predicts each result from its own copy of the stacks and
	// cutoffs, and keeps the handed-out buffers so that frees can return real ones.
	class pool_scoreboard;
		logic [ID_W-1:0]  pkt_slot[PACKET_COUNT];
		int               pkt_cnt;
		logic [ID_W-1:0]  pld_slot[3][32];
		int               pld_cap[3];
		int               pld_cnt[3];
		logic [LEN_W-1:0] cutoff[3];
		pool_result_t     owed_results[$];
		logic [ID_W-1:0]  held_pkts[$];
		held_payload_t    held_plds[$];
		int               errors;

		function void reset_state();
			int base;
			pld_cap[0] = SMALL_COUNT;
			pld_cap[1] = MEDIUM_COUNT;
			pld_cap[2] = LARGE_COUNT;
			pkt_cnt = PACKET_COUNT;
			for (int i = 0; i < PACKET_COUNT; i++)
				pkt_slot[i] = ID_W'(PACKET_COUNT - 1 - i);
			base = 0;
			for (int k = 0; k < 3; k++) begin
				pld_cnt[k] = pld_cap[k];
				for (int i = 0; i < pld_cap[k]; i++)
					pld_slot[k][i] = ID_W'(base + pld_cap[k] - 1 - i);
				base += pld_cap[k];
			end
			cutoff[CFG_CUTOFF_SMALL]  = CUTOFF_SMALL_RST;
			cutoff[CFG_CUTOFF_MEDIUM] = CUTOFF_MEDIUM_RST;
			cutoff[CFG_CUTOFF_LARGE]  = CUTOFF_LARGE_RST;
			errors = 0;
		endfunction

		function void set_cutoff(cfg_index_t idx, logic [LEN_W-1:0] value);
			cutoff[idx] = value;
		endfunction

		// First class in the order small, medium, large whose cutoff covers the length.
		function class_t size_class(logic [LEN_W-1:0] len);
			if (cutoff[CFG_CUTOFF_SMALL] >= len) return CLASS_SMALL;
			if (cutoff[CFG_CUTOFF_MEDIUM] >= len) return CLASS_MEDIUM;
			if (cutoff[CFG_CUTOFF_LARGE] >= len) return CLASS_LARGE;
			return CLASS_NONE;
		endfunction

		function bit pkt_pop(output logic [ID_W-1:0] id);
			id = '0;
			if (pkt_cnt == 0) return 1'b0;
			pkt_cnt--;
			id = pkt_slot[pkt_cnt];
			return 1'b1;
		endfunction

		function bit pkt_push(logic [ID_W-1:0] id);
			if (pkt_cnt >= PACKET_COUNT) return 1'b0;
			pkt_slot[pkt_cnt] = id;
			pkt_cnt++;
			return 1'b1;
		endfunction

		function bit pld_pop(class_t c, output logic [ID_W-1:0] id);
			int k;
			k = int'(c);
			id = '0;
			if (pld_cnt[k] == 0) return 1'b0;
			pld_cnt[k]--;
			id = pld_slot[k][pld_cnt[k]];
			return 1'b1;
		endfunction

		function bit pld_push(class_t c, logic [ID_W-1:0] id);
			int k;
			k = int'(c);
			if (pld_cnt[k] >= pld_cap[k]) return 1'b0;
			pld_slot[k][pld_cnt[k]] = id;
			pld_cnt[k]++;
			return 1'b1;
		endfunction

		// Work out the result of one accepted request and queue it.
		function void note_request(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
				logic [ID_W-1:0] pkt_in, logic [ID_W-1:0] pld_in);
			pool_result_t  r;
			class_t        c;
			logic [ID_W-1:0] p;
			logic [ID_W-1:0] b;
			held_payload_t hp;
			r.status = STATUS_OK;
			r.pkt = '0;
			r.pld = '0;
			r.cls = CLASS_SMALL;
			c = size_class(len);
			if (op == OP_ALLOC_PLD || op == OP_ALLOC_BOTH || op == OP_FREE_PLD ||
					op == OP_FREE_BOTH)
				r.cls = (c == CLASS_NONE) ? CLASS_SMALL : c;
			case (op)
				OP_ALLOC_PKT: begin
					if (pkt_pop(p)) begin
						r.pkt = p;
						held_pkts.push_back(p);
					end else
						r.status = STATUS_NO_PACKET;
				end
				OP_ALLOC_PLD: begin
					if (c == CLASS_NONE)
						r.status = STATUS_TOO_LONG;
					else if (pld_pop(c, b)) begin
						r.pld = b;
						hp.id = b;
						hp.len = len;
						held_plds.push_back(hp);
					end else
						r.status = STATUS_NO_PAYLOAD;
				end
				OP_ALLOC_BOTH: begin
					if (!pkt_pop(p))
						r.status = STATUS_NO_PACKET;
					else begin
						if (c == CLASS_NONE)
							r.status = STATUS_TOO_LONG;
						else if (pld_pop(c, b)) begin
							r.pkt = p;
							r.pld = b;
							held_pkts.push_back(p);
							hp.id = b;
							hp.len = len;
							held_plds.push_back(hp);
						end else
							r.status = STATUS_NO_PAYLOAD;
						// no payload: the descriptor goes straight back on top
						if (r.status != STATUS_OK)
							void'(pkt_push(p));
					end
				end
				OP_FREE_PKT: begin
					if (!pkt_push(pkt_in))
						r.status = STATUS_PACKET_FULL;
				end
				OP_FREE_PLD, OP_FREE_BOTH: begin
					// payload first; a rejected payload stops the packet push
					if (c == CLASS_NONE)
						r.status = STATUS_TOO_LONG;
					else if (!pld_push(c, pld_in))
						r.status = STATUS_PAYLOAD_FULL;
					else if (op == OP_FREE_BOTH && !pkt_push(pkt_in))
						r.status = STATUS_PACKET_FULL;
				end
				default: ;
			endcase
			owed_results.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [ID_W-1:0] gp,
				logic [ID_W-1:0] gl, logic [CLASS_W-1:0] cls);
			pool_result_t r;
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d packet %0d payload %0d class %0d",
					$time, st, gp, gl, cls);
				errors++;
				return;
			end
			r = owed_results.pop_front();
			if (st !== r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, r.status, st);
				errors++;
			end
			if (gp !== r.pkt) begin
				$display("%0t: granted_packet expected %0d actual %0d", $time, r.pkt, gp);
				errors++;
			end
			if (gl !== r.pld) begin
				$display("%0t: granted_payload expected %0d actual %0d", $time, r.pld, gl);
				errors++;
			end
			if (cls !== r.cls) begin
				$display("%0t: payload_class expected %0d actual %0d", $time, r.cls, cls);
				errors++;
			end
		endfunction

		function logic [ID_W-1:0] take_packet();
			int idx;
			logic [ID_W-1:0] id;
			idx = $urandom_range(0, held_pkts.size() - 1);
			id = held_pkts[idx];
			held_pkts.delete(idx);
			return id;
		endfunction

		function held_payload_t take_payload();
			int idx;
			held_payload_t hp;
			idx = $urandom_range(0, held_plds.size() - 1);
			hp = held_plds[idx];
			held_plds.delete(idx);
			return hp;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [OP_W-1:0] operation;
	logic [LEN_W-1:0] payload_length;
	logic [ID_W-1:0] packet_id;
	logic [ID_W-1:0] payload_id;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] granted_packet;
	logic [ID_W-1:0] granted_payload;
	logic [CLASS_W-1:0] payload_class;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [LEN_W-1:0] wr_data;

	pool_scoreboard ledger;
	int cycle_count = 0;
	int gap_odds;           // one item in gap_odds is followed by an idle burst; 0 = none

	always #(CLK_PERIOD / 2) clk = ~clk;

	size_class_buffer_pool #(
		.PACKET_COUNT(PACKET_COUNT),
		.SMALL_COUNT(SMALL_COUNT),
		.MEDIUM_COUNT(MEDIUM_COUNT),
		.LARGE_COUNT(LARGE_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.payload_length(payload_length),
		.packet_id(packet_id),
		.payload_id(payload_id),
		.done(done),
		.status(status),
		.granted_packet(granted_packet),
		.granted_payload(granted_payload),
		.payload_class(payload_class),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Watchdog: end the run if the pool stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Result monitor: done marks a one-cycle result transaction; take it at the edge.
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_result(status, granted_packet, granted_payload, payload_class);
	end

	// Present one request at the falling edge and hold it until an edge sees busy low.
	// Start stays high on return so that back-to-back requests keep it asserted.
	task automatic send_request(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
			logic [ID_W-1:0] pkt, logic [ID_W-1:0] pld);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		payload_length <= len;
		packet_id <= pkt;
		payload_id <= pld;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ledger.note_request(op, len, pkt, pld);
	endtask

	task automatic idle_for(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1)
			@(negedge clk);
	endtask

	// Insert a random idle burst after a transaction, as the current phase allows.
	task automatic maybe_idle();
		if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1)
			idle_for($urandom_range(1, 17));
	endtask

	// Drop start, wait for every owed result, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_cutoff(cfg_index_t idx, logic [LEN_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		ledger.set_cutoff(idx, value);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Lengths cluster around the live cutoffs half the time so boundaries get hit.
	function automatic logic [LEN_W-1:0] rand_length();
		int v;
		if ($urandom_range(0, 1) == 0) begin
			v = int'(ledger.cutoff[$urandom_range(0, 2)]) + $urandom_range(0, 2) - 1;
			if (v < 0) v = 0;
			if (v > int'(LEN_MAX)) v = int'(LEN_MAX);
			return LEN_W'(v);
		end
		return LEN_W'($urandom_range(0, int'(LEN_MAX)));
	endfunction

	// One random request: mostly allocs and frees of buffers actually handed out,
	// with stray ids, mismatched lengths and the odd ignored opcode as noise.
	task automatic rand_request(int alloc_pct);
		int roll;
		logic [OP_W-1:0] op;
		logic [LEN_W-1:0] len;
		logic [ID_W-1:0] pkt;
		logic [ID_W-1:0] pld;
		held_payload_t hp;
		roll = $urandom_range(0, 99);
		len = rand_length();
		pkt = ID_W'($urandom_range(0, int'(ID_MAX)));
		pld = ID_W'($urandom_range(0, int'(ID_MAX)));
		if (roll < alloc_pct) begin
			case ($urandom_range(0, 2))
				0: op = OP_ALLOC_PKT;
				1: op = OP_ALLOC_PLD;
				default: op = OP_ALLOC_BOTH;
			endcase
		end else if (roll < 98) begin
			case ($urandom_range(0, 2))
				0: op = OP_FREE_PKT;
				1: op = OP_FREE_PLD;
				default: op = OP_FREE_BOTH;
			endcase
			if (op != OP_FREE_PLD && ledger.held_pkts.size() != 0 &&
					$urandom_range(0, 9) != 0)
				pkt = ledger.take_packet();
			if (op != OP_FREE_PKT && ledger.held_plds.size() != 0 &&
					$urandom_range(0, 9) != 0) begin
				hp = ledger.take_payload();
				pld = hp.id;
				if ($urandom_range(0, 4) != 0)
					len = hp.len;
			end
		end else
			op = ($urandom_range(0, 1) == 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
		send_request(op, len, pkt, pld);
	endtask

	// One random phase under fixed cutoffs; write them only once the pool is idle.
	task automatic run_phase(logic [LEN_W-1:0] cut_s, logic [LEN_W-1:0] cut_m,
			logic [LEN_W-1:0] cut_l, int items, int alloc_pct, int odds, bit hold_mid);
		drain();
		write_cutoff(CFG_CUTOFF_SMALL, cut_s);
		write_cutoff(CFG_CUTOFF_MEDIUM, cut_m);
		write_cutoff(CFG_CUTOFF_LARGE, cut_l);
		gap_odds = odds;
		for (int i = 0; i < items; i++) begin
			rand_request(alloc_pct);
			maybe_idle();
			// hold the sender until every owed result is back
			if (hold_mid && i == items / 2)
				drain();
		end
	endtask

	task automatic directed_requests();
		gap_odds = 3;
		// full stacks reject frees; free both stops at the rejected payload
		send_request(OP_FREE_PKT, 7'd0, 5'd5, 5'd0); maybe_idle();
		send_request(OP_FREE_PLD, 7'd110, 5'd0, 5'd3); maybe_idle();
		send_request(OP_FREE_BOTH, 7'd0, ID_MAX, ID_MAX); maybe_idle();
		// payload goes back, packet stack still full: payload stays freed
		send_request(OP_ALLOC_PLD, 7'd0, 5'd0, 5'd0); maybe_idle();
		send_request(OP_FREE_BOTH, 7'd0, 5'd7, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PKT, LEN_MAX, ID_MAX, ID_MAX); maybe_idle();
		// class boundaries at the reset cutoffs, then drain the large class
		send_request(OP_ALLOC_PLD, CUTOFF_SMALL_RST, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PLD, CUTOFF_SMALL_RST + 7'd1, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PLD, CUTOFF_MEDIUM_RST, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PLD, CUTOFF_MEDIUM_RST + 7'd1, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PLD, CUTOFF_LARGE_RST, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PLD, 7'd100, 5'd0, 5'd0); maybe_idle();
		// alloc both failing on the payload puts the descriptor back
		send_request(OP_ALLOC_BOTH, CUTOFF_LARGE_RST + 7'd1, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_BOTH, LEN_MAX, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_BOTH, 7'd90, 5'd0, 5'd0); maybe_idle();
		send_request(OP_ALLOC_BOTH, 7'd1, 5'd0, 5'd0); maybe_idle();
		// too-long free, then out-of-range ids stored as given and handed out again
		send_request(OP_FREE_PLD, LEN_MAX, 5'd0, 5'd5); maybe_idle();
		send_request(OP_FREE_PLD, 7'd100, 5'd0, ID_MAX); maybe_idle();
		send_request(OP_ALLOC_PLD, CUTOFF_LARGE_RST, 5'd0, 5'd0); maybe_idle();
		send_request(OP_FREE_BOTH, 7'd50, 5'd0, 5'd21); maybe_idle();
		send_request(OP_FREE_PKT, 7'd0, 5'd30, 5'd0); maybe_idle();
		send_request(OP_ALLOC_PKT, 7'd0, 5'd0, 5'd0); maybe_idle();
		// ignored opcodes still answer with an all-zero result
		send_request(OP_RESERVED_LO, LEN_MAX, ID_MAX, ID_MAX); maybe_idle();
		send_request(OP_RESERVED_HI, 7'd0, 5'd0, 5'd0); maybe_idle();
	endtask

	initial begin
		ledger = new();
		ledger.reset_state();
		gap_odds = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ALLOC_PKT;
		payload_length = '0;
		packet_id = '0;
		payload_id = '0;
		wr_en = 1'b0;
		wr_index = CFG_CUTOFF_SMALL;
		wr_data = '0;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_requests();

		// cutoff settings: extremes, unsorted, back to reset, then two more phases, the last without idle bursts
		run_phase(7'd0, 7'd0, 7'd0, 60, 50, 3, 1'b0);
		run_phase(LEN_MAX, LEN_MAX, LEN_MAX, 60, 70, 0, 1'b0);
		run_phase(7'd100, 7'd5, LEN_MAX, 60, 50, 2, 1'b1);
		run_phase(7'd0, LEN_MAX, 7'd0, 60, 50, 4, 1'b0);
		run_phase(CUTOFF_SMALL_RST, CUTOFF_MEDIUM_RST, CUTOFF_LARGE_RST, 80, 80, 3, 1'b0);
		run_phase(7'd30, 7'd60, 7'd90, 80, 20, 2, 1'b0);
		run_phase(7'd5, 7'd40, LEN_MAX, 100, 50, 0, 1'b0);

		drain();
		if (ledger.errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
